// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, status codes and the alphabet lookup for the strict base64 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int unsigned CountW = 21;
  localparam int unsigned AccW   = 18;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW   = $clog2(FifoDepth);
  localparam int unsigned FillW  = $clog2(FifoDepth + 1);
  localparam int unsigned MaxRes = 3;

  localparam logic [CountW-1:0] COUNT_MAX     = {CountW{1'b1}};
  localparam logic [CountW-1:0] MAX_CHARS_RST = CountW'(1048576);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR = 3'd1;
  localparam logic [2:0] ST_BAD_PAD  = 3'd2;
  localparam logic [2:0] ST_BAD_LEN  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       final_res;
  } out_item_t;

  // alphabet lookup; bit 6 set means not a digit
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = 7'd64;
    if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B) v = 7'd62;
    else if (c == 8'h2F) v = 7'd63;
    return v;
  endfunction

endpackage

// ===== design/strict_base64_decoder.sv =====
// ----------------------------------------------------------------------------
// strict_base64_decoder
// Strict standard-alphabet base64 decoder, one character in per unstalled cycle,
// decoded bytes and error results out through a small result queue.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   in      | in        | in_valid/in_stall  | in_data (character, end_of_stream)
//   out     | out       | out_valid/out_stall| out_data (data_byte, status, final_res)
//   cfg     | in        | cfg_write          | cfg_data (max_chars)
//
// One character per cycle while in_stall is low; a character is decoded in the
// cycle it is taken and its results sit in a four-entry queue the cycle after.
// The queue drains one result per cycle while out_stall is low; a fourth-position
// character needs three free entries, any other one entry, else in_stall rises.
// Reset (rst, synchronous) empties the queue, clears the stream state and
// sets max_chars to 1048576.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module strict_base64_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  b64d_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output b64d_pkg::out_item_t               out_data,
  input  logic                              cfg_write,
  input  logic [b64d_pkg::CountW-1:0]       cfg_data
);

  logic [b64d_pkg::CountW-1:0] max_chars;
  logic [1:0]                  quartet_position, quartet_position_next;
  logic [b64d_pkg::AccW-1:0]   acc, acc_next;
  logic                        pad_seen, pad_seen_next;
  logic [b64d_pkg::CountW-1:0] char_count, char_count_next;
  logic                        failed, failed_next;

  b64d_pkg::out_item_t         fifo [b64d_pkg::FifoDepth];
  logic [b64d_pkg::PtrW-1:0]   head, tail;
  logic [b64d_pkg::FillW-1:0]  fill;

  logic                        in_acc, pop;
  logic [1:0]                  push_n;
  b64d_pkg::out_item_t         res [b64d_pkg::MaxRes];
  logic [b64d_pkg::PtrW-1:0]   wr_ptr [b64d_pkg::MaxRes];

  // a fourth-position character may push three results
  always_comb begin
    if (quartet_position == 2'd3 && !failed) begin
      in_stall = fill > b64d_pkg::FillW'(b64d_pkg::FifoDepth - b64d_pkg::MaxRes);
    end else begin
      in_stall = fill == b64d_pkg::FillW'(b64d_pkg::FifoDepth);
    end
  end

  assign in_acc    = in_valid && !in_stall;
  assign out_valid = fill != '0;
  assign out_data  = fifo[head];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    logic                        eos, is_pad, bad_digit, err;
    logic [6:0]                  v;
    logic [5:0]                  d;
    logic [b64d_pkg::CountW-1:0] cnt;
    logic [23:0]                 full;
    logic [2:0]                  code;
    logic [1:0]                  n;

    eos       = in_data.end_of_stream;
    is_pad    = in_data.character == b64d_pkg::PAD_CHAR;
    v         = b64d_pkg::sextet_of(in_data.character);
    bad_digit = v[6];
    d         = is_pad ? 6'd0 : v[5:0];
    cnt       = (char_count != b64d_pkg::COUNT_MAX) ? char_count + 1'b1 : char_count;
    full      = {acc, d};
    n         = pad_seen ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
    err       = 1'b0;
    code      = b64d_pkg::ST_OK;

    quartet_position_next = quartet_position;
    acc_next              = acc;
    pad_seen_next         = pad_seen;
    char_count_next       = char_count;
    failed_next           = failed;
    push_n                = 2'd0;
    for (int k = 0; k < b64d_pkg::MaxRes; k++) begin
      res[k] = '{data_byte: full[23-8*k -: 8], status: b64d_pkg::ST_OK,
                 final_res: eos && (k == int'(n) - 1)};
    end

    if (in_acc) begin
      if (failed) begin
        if (eos) begin
          quartet_position_next = '0;
          acc_next              = '0;
          pad_seen_next         = 1'b0;
          char_count_next       = '0;
          failed_next           = 1'b0;
        end
      end else if (cnt > max_chars) begin
        err  = 1'b1;
        code = b64d_pkg::ST_TOO_LONG;
      end else begin
        char_count_next = cnt;
        if (quartet_position != 2'd3) begin
          if (quartet_position == 2'd2 && is_pad) begin
            if (acc[3:0] != 4'd0) begin
              err  = 1'b1;
              code = b64d_pkg::ST_BAD_PAD;
            end
          end else if (bad_digit) begin
            err  = 1'b1;
            code = b64d_pkg::ST_BAD_CHAR;
          end
          if (!err) begin
            pad_seen_next         = quartet_position == 2'd2 && is_pad;
            acc_next              = {acc[b64d_pkg::AccW-7:0], d};
            quartet_position_next = quartet_position + 2'd1;
            if (eos) begin
              err  = 1'b1;
              code = b64d_pkg::ST_BAD_LEN;
            end
          end
        end else begin
          if (pad_seen && !is_pad) begin
            err  = 1'b1;
            code = b64d_pkg::ST_BAD_PAD;
          end else if (is_pad) begin
            // pad in the last position only on the final quartet, clean tail bits
            if (!eos || (!pad_seen && acc[1:0] != 2'd0)) begin
              err  = 1'b1;
              code = b64d_pkg::ST_BAD_PAD;
            end
          end else if (bad_digit) begin
            err  = 1'b1;
            code = b64d_pkg::ST_BAD_CHAR;
          end
          if (!err) begin
            push_n                = n;
            quartet_position_next = '0;
            acc_next              = '0;
            pad_seen_next         = 1'b0;
            if (eos) char_count_next = '0;
          end
        end
      end

      if (err) begin
        push_n                = 2'd1;
        res[0]                = '{data_byte: 8'd0, status: code, final_res: 1'b1};
        quartet_position_next = '0;
        acc_next              = '0;
        pad_seen_next         = 1'b0;
        char_count_next       = '0;
        failed_next           = !eos;
      end
    end

    for (int k = 0; k < b64d_pkg::MaxRes; k++) begin
      wr_ptr[k] = tail + b64d_pkg::PtrW'(k);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < b64d_pkg::MaxRes; k++) begin
      if (k < int'(push_n)) fifo[wr_ptr[k]] <= res[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars        <= b64d_pkg::MAX_CHARS_RST;
      quartet_position <= '0;
      acc              <= '0;
      pad_seen         <= 1'b0;
      char_count       <= '0;
      failed           <= 1'b0;
      head             <= '0;
      tail             <= '0;
      fill             <= '0;
    end else begin
      if (cfg_write) max_chars <= cfg_data;
      quartet_position <= quartet_position_next;
      acc              <= acc_next;
      pad_seen         <= pad_seen_next;
      char_count       <= char_count_next;
      failed           <= failed_next;
      tail             <= tail + b64d_pkg::PtrW'(push_n);
      head             <= head + b64d_pkg::PtrW'(pop);
      fill             <= fill + b64d_pkg::FillW'(push_n) - b64d_pkg::FillW'(pop);
    end
  end

  `ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, fill <= b64d_pkg::FillW'(b64d_pkg::FifoDepth), "result queue overfilled")
  `ASSERT_NEXT(a_drop_no_push, clk, rst, in_acc && failed, fill <= $past(fill), "result pushed while dropping")
  `ASSERT_IMPLY(a_err_final, clk, rst, out_valid && out_data.status != b64d_pkg::ST_OK, out_data.final_res, "error result not final")
  `ASSERT_IMPLY(a_pos_count, clk, rst, quartet_position != 2'd0, char_count != '0, "quartet position without characters")

endmodule
